// ----- hdl/c_escape_string_decoder_defines.svh -----
// ---------------------------------------------------------------------------
// c_escape_string_decoder_defines
// Assertion macros shared by the escape decoder RTL.
// ---------------------------------------------------------------------------
`ifndef C_ESCAPE_STRING_DECODER_DEFINES_SVH
`define C_ESCAPE_STRING_DECODER_DEFINES_SVH

`ifndef SYNTH
`define CED_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("ced assertion failed");
`define CED_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("ced assertion failed");
`else
`define CED_ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define CED_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

// ----- hdl/ced_pkg.sv -----
// ---------------------------------------------------------------------------
// ced_pkg
// Types, codes and character tables of the C string escape decoder.
// ---------------------------------------------------------------------------
package ced_pkg;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_HEX1   = 2'd2,
      MODE_HEX2   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_TRAIL_BS  = 3'd1;
   localparam logic [2:0] ERR_HEX_MISS  = 3'd2;
   localparam logic [2:0] ERR_HEX_ZERO  = 3'd3;
   localparam logic [2:0] ERR_UNK_ESC   = 3'd4;

   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_X          = 8'h78;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [2:0]  err_code;
      logic [15:0] err_pos;
      logic [15:0] out_count;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0]  n;
      result_type  r0;
      result_type  r1;
   } push_type;

   function automatic result_type byte_res(input logic [7:0] v);
      result_type r;
      r = '0;
      r.kind = KIND_BYTE;
      r.data = v;
      return r;
   endfunction

   function automatic result_type err_res(input logic [2:0] code, input logic [15:0] pos);
      result_type r;
      r = '0;
      r.kind = KIND_ERROR;
      r.err_code = code;
      r.err_pos = pos;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic result_type done_res(input logic [15:0] count);
      result_type r;
      r = '0;
      r.kind = KIND_DONE;
      r.out_count = count;
      r.last = 1'b1;
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // {valid, byte}
   function automatic logic [8:0] escape_value(input logic [7:0] c);
      logic [8:0] r;
      case (c)
         8'h6E: r = {1'b1, 8'h0A};
         8'h74: r = {1'b1, 8'h09};
         8'h72: r = {1'b1, 8'h0D};
         8'h30: r = {1'b1, 8'h00};
         8'h5C: r = {1'b1, 8'h5C};
         8'h22: r = {1'b1, 8'h22};
         8'h27: r = {1'b1, 8'h27};
         8'h62: r = {1'b1, 8'h08};
         8'h66: r = {1'b1, 8'h0C};
         8'h76: r = {1'b1, 8'h0B};
         8'h61: r = {1'b1, 8'h07};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/c_escape_string_decoder.sv -----
// ---------------------------------------------------------------------------
// c_escape_string_decoder
// Decodes C string literal bodies, one byte beat at a time.
//
//   channel  direction  beat
//   req_     in         op, ch
//   rsp_     out        kind, data, err_code, err_pos, out_count, last
//
// One beat per cycle in, one result beat per cycle out, unless req_stall or rsp_stall holds the flow.
// An input beat reaches its first result through the queue write and then the output register.
// A beat that yields two results pushes both at once; the 4-entry queue
// absorbs them, req_stall rises when fewer than two entries are free.
// Synchronous reset clears decoder state, queue pointers and rsp_valid;
// req_stall is held high while reset is asserted.
// ---------------------------------------------------------------------------
module c_escape_string_decoder #(
   parameter longint unsigned MAX_LEN = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic [2:0]  rsp_err_code,
   output logic [15:0] rsp_err_pos,
   output logic [15:0] rsp_out_count,
   output logic        rsp_last
);

   ced_pkg::push_type   push;
   ced_pkg::result_type head;
   ced_pkg::result_type rsp;
   logic                q_ready;
   logic                q_nonempty;
   logic                pop;
   logic                accept;

   assign req_stall = reset || !q_ready;
   assign accept    = req_valid && !req_stall;

   ced_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .op     (req_op),
      .ch     (req_ch),
      .push_o (push)
   );

   ced_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_i   (push),
      .pop      (pop),
      .ready    (q_ready),
      .nonempty (q_nonempty),
      .head     (head)
   );

   ced_back u_back (
      .clock     (clock),
      .reset     (reset),
      .nonempty  (q_nonempty),
      .head      (head),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_kind      = rsp.kind;
   assign rsp_data      = rsp.data;
   assign rsp_err_code  = rsp.err_code;
   assign rsp_err_pos   = rsp.err_pos;
   assign rsp_out_count = rsp.out_count;
   assign rsp_last      = rsp.last;

endmodule

// ----- hdl/ced_front.sv -----
// ---------------------------------------------------------------------------
// ced_front
// Accepts string beats, runs the escape state machine and pushes zero to
// two results per beat into the queue.
// ---------------------------------------------------------------------------
module ced_front #(
   parameter longint unsigned MAX_LEN = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              op,
   input  logic [7:0]        ch,
   output ced_pkg::push_type push_o
);

   localparam int CNT_W = $clog2(MAX_LEN + 64'd1);
   localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_LEN);

   ced_pkg::mode_type mode_ff, mode_in;
   logic [3:0]        fh_ff, fh_in;
   logic [CNT_W-1:0]  bi_ff, bi_in;
   logic [CNT_W-1:0]  ec_ff, ec_in;
   logic              failed_ff, failed_in;
   logic [CNT_W-1:0]  ec1;
   logic [4:0]        hex;
   logic [8:0]        esc;
   logic [7:0]        hv;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == MAX_C) ? v : v + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] sub_floor(input logic [CNT_W-1:0] v,
                                                  input logic [1:0] d);
      return (v >= CNT_W'(d)) ? v - CNT_W'(d) : '0;
   endfunction

   function automatic logic [15:0] to16(input logic [CNT_W-1:0] v);
      logic [CNT_W+15:0] w;
      w = {16'd0, v};
      return w[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ced_pkg::MODE_NORMAL;
         fh_ff     <= 4'd0;
         bi_ff     <= '0;
         ec_ff     <= '0;
         failed_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         fh_ff     <= fh_in;
         bi_ff     <= bi_in;
         ec_ff     <= ec_in;
         failed_ff <= failed_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      fh_in     = fh_ff;
      bi_in     = bi_ff;
      ec_in     = ec_ff;
      failed_in = failed_ff;
      push_o    = '0;
      hex       = ced_pkg::hex_value(ch);
      esc       = ced_pkg::escape_value(ch);
      hv        = {fh_ff, hex[3:0]};
      ec1       = sat_inc(ec_ff);
      if (accept) begin
         if (op) begin
            if (!failed_ff) begin
               case (mode_ff)
                  ced_pkg::MODE_ESC: begin
                     push_o.n  = 2'd1;
                     push_o.r0 = ced_pkg::err_res(ced_pkg::ERR_TRAIL_BS,
                                                  to16(sub_floor(bi_ff, 2'd1)));
                  end
                  ced_pkg::MODE_HEX1: begin
                     push_o.n  = 2'd1;
                     push_o.r0 = ced_pkg::err_res(ced_pkg::ERR_HEX_MISS,
                                                  to16(sub_floor(bi_ff, 2'd2)));
                  end
                  ced_pkg::MODE_HEX2: begin
                     if (fh_ff == 4'd0) begin
                        push_o.n  = 2'd1;
                        push_o.r0 = ced_pkg::err_res(ced_pkg::ERR_HEX_ZERO,
                                                     to16(sub_floor(bi_ff, 2'd2)));
                     end else begin
                        push_o.n  = 2'd2;
                        push_o.r0 = ced_pkg::byte_res({4'd0, fh_ff});
                        push_o.r1 = ced_pkg::done_res(to16(ec1));
                     end
                  end
                  default: begin
                     push_o.n  = 2'd1;
                     push_o.r0 = ced_pkg::done_res(to16(ec_ff));
                  end
               endcase
            end
            mode_in   = ced_pkg::MODE_NORMAL;
            fh_in     = 4'd0;
            bi_in     = '0;
            ec_in     = '0;
            failed_in = 1'b0;
         end else begin
            bi_in = sat_inc(bi_ff);
            if (!failed_ff) begin
               case (mode_ff)
                  ced_pkg::MODE_HEX2: begin
                     mode_in = ced_pkg::MODE_NORMAL;
                     push_o.n = 2'd1;
                     if (hex[4]) begin
                        if (hv == 8'd0) begin
                           push_o.r0 = ced_pkg::err_res(ced_pkg::ERR_HEX_ZERO,
                                                        to16(sub_floor(bi_ff, 2'd1)));
                           failed_in = 1'b1;
                        end else begin
                           push_o.r0 = ced_pkg::byte_res(hv);
                           ec_in     = ec1;
                        end
                     end else if (fh_ff == 4'd0) begin
                        push_o.r0 = ced_pkg::err_res(ced_pkg::ERR_HEX_ZERO,
                                                     to16(sub_floor(bi_ff, 2'd2)));
                        failed_in = 1'b1;
                     end else begin
                        push_o.r0 = ced_pkg::byte_res({4'd0, fh_ff});
                        if (ch == ced_pkg::CH_BACKSLASH) begin
                           mode_in = ced_pkg::MODE_ESC;
                           ec_in   = ec1;
                        end else begin
                           push_o.n  = 2'd2;
                           push_o.r1 = ced_pkg::byte_res(ch);
                           ec_in     = sat_inc(ec1);
                        end
                     end
                  end
                  ced_pkg::MODE_ESC: begin
                     if (ch == ced_pkg::CH_X) begin
                        mode_in = ced_pkg::MODE_HEX1;
                     end else if (esc[8]) begin
                        mode_in   = ced_pkg::MODE_NORMAL;
                        push_o.n  = 2'd1;
                        push_o.r0 = ced_pkg::byte_res(esc[7:0]);
                        ec_in     = ec1;
                     end else begin
                        mode_in   = ced_pkg::MODE_NORMAL;
                        push_o.n  = 2'd1;
                        push_o.r0 = ced_pkg::err_res(ced_pkg::ERR_UNK_ESC,
                                                     to16(sub_floor(bi_ff, 2'd1)));
                        failed_in = 1'b1;
                     end
                  end
                  ced_pkg::MODE_HEX1: begin
                     if (hex[4]) begin
                        fh_in   = hex[3:0];
                        mode_in = ced_pkg::MODE_HEX2;
                     end else begin
                        mode_in   = ced_pkg::MODE_NORMAL;
                        push_o.n  = 2'd1;
                        push_o.r0 = ced_pkg::err_res(ced_pkg::ERR_HEX_MISS,
                                                     to16(sub_floor(bi_ff, 2'd2)));
                        failed_in = 1'b1;
                     end
                  end
                  default: begin
                     if (ch == ced_pkg::CH_BACKSLASH) begin
                        mode_in = ced_pkg::MODE_ESC;
                     end else begin
                        push_o.n  = 2'd1;
                        push_o.r0 = ced_pkg::byte_res(ch);
                        ec_in     = ec1;
                     end
                  end
               endcase
            end
         end
      end
   end

endmodule

// ----- hdl/ced_queue.sv -----
// ---------------------------------------------------------------------------
// ced_queue
// Four-entry result queue, up to two pushes and one pop per cycle.
// ---------------------------------------------------------------------------
`include "c_escape_string_decoder_defines.svh"

module ced_queue (
   input  logic                clock,
   input  logic                reset,
   input  ced_pkg::push_type   push_i,
   input  logic                pop,
   output logic                ready,
   output logic                nonempty,
   output ced_pkg::result_type head
);

   ced_pkg::result_type        mem_ff [ced_pkg::QDEPTH];
   logic [ced_pkg::QPTR_W-1:0] wr_ff, wr_in;
   logic [ced_pkg::QPTR_W-1:0] rd_ff, rd_in;
   logic [ced_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [ced_pkg::QPTR_W-1:0] wr_next;

   assign wr_next  = wr_ff + 1'b1;
   assign ready    = count_ff <= ced_pkg::QCNT_W'(ced_pkg::QDEPTH - 2);
   assign nonempty = count_ff != '0;
   assign head     = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff + ced_pkg::QPTR_W'(push_i.n);
      rd_in    = rd_ff + ced_pkg::QPTR_W'(pop);
      count_in = count_ff + ced_pkg::QCNT_W'(push_i.n) - ced_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i.n != 2'd0) begin
         mem_ff[wr_ff] <= push_i.r0;
      end
      if (push_i.n == 2'd2) begin
         mem_ff[wr_next] <= push_i.r1;
      end
   end

   `CED_ASSERT_IMPLY(a_count_max, clock, reset, 1'b1, count_ff <= ced_pkg::QDEPTH)
   `CED_ASSERT_IMPLY(a_push_room, clock, reset, push_i.n != 2'd0, ready)
   `CED_ASSERT_IMPLY(a_pop_nonempty, clock, reset, pop, nonempty)
   `CED_ASSERT_IMPLY(a_pair_order, clock, reset, push_i.n == 2'd2, !push_i.r0.last)

endmodule

// ----- hdl/ced_back.sv -----
// ---------------------------------------------------------------------------
// ced_back
// Output register: drains the queue onto the result channel.
// ---------------------------------------------------------------------------
module ced_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                nonempty,
   input  ced_pkg::result_type head,
   output logic                pop,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output ced_pkg::result_type rsp
);

   logic                valid_ff, valid_in;
   ced_pkg::result_type res_ff, res_in;

   always_comb begin
      pop      = nonempty && (!valid_ff || !rsp_stall);
      valid_in = pop || (valid_ff && rsp_stall);
      res_in   = pop ? head : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;

endmodule

// ----- tb/c_escape_string_decoder_checker.sv -----
// ---------------------------------------------------------------------------
// c_escape_string_decoder_checker
// Watches both channels of the escape decoder, predicts the result beats
// of every accepted input beat and compares them field by field, in order.
// ---------------------------------------------------------------------------
module c_escape_string_decoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_ch,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [7:0]  rsp_data,
   input  logic [2:0]  rsp_err_code,
   input  logic [15:0] rsp_err_pos,
   input  logic [15:0] rsp_out_count,
   input  logic        rsp_last,
   output int          fail_count,
   output int          outstanding,
   output int          results_seen,
   output int          errors_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   ced_pkg::mode_type   dec_mode;
   logic [3:0]          pending_hex;
   logic [15:0]         byte_idx;
   logic [15:0]         emitted;
   logic                str_failed;
   ced_pkg::result_type expected_results[$];
   ced_pkg::result_type want;

   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [15:0] floor_sub(input logic [15:0] v, input logic [15:0] d);
      return (v >= d) ? v - d : 16'd0;
   endfunction

   function automatic int hex_digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic int escaped_byte(input logic [7:0] c);
      case (c)
         "n":  return 'h0A;
         "t":  return 'h09;
         "r":  return 'h0D;
         "0":  return 'h00;
         "\\": return 'h5C;
         "\"": return 'h22;
         "'":  return 'h27;
         "b":  return 'h08;
         "f":  return 'h0C;
         "v":  return 'h0B;
         "a":  return 'h07;
         default: return -1;
      endcase
   endfunction

   task automatic clear_string();
      dec_mode = ced_pkg::MODE_NORMAL;
      pending_hex = 4'd0;
      byte_idx = 16'd0;
      emitted = 16'd0;
      str_failed = 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] v);
      ced_pkg::result_type r;
      r = '0;
      r.kind = ced_pkg::KIND_BYTE;
      r.data = v;
      expected_results.push_back(r);
      emitted = bump(emitted);
   endtask

   task automatic push_error(input logic [2:0] code, input logic [15:0] pos);
      ced_pkg::result_type r;
      r = '0;
      r.kind = ced_pkg::KIND_ERROR;
      r.err_code = code;
      r.err_pos = pos;
      r.last = 1'b1;
      expected_results.push_back(r);
      str_failed = 1'b1;
      dec_mode = ced_pkg::MODE_NORMAL;
   endtask

   task automatic push_done();
      ced_pkg::result_type r;
      r = '0;
      r.kind = ced_pkg::KIND_DONE;
      r.out_count = emitted;
      r.last = 1'b1;
      expected_results.push_back(r);
   endtask

   task automatic decode_beat(input logic op, input logic [7:0] ch);
      logic [15:0] pos;
      logic [7:0]  v8;
      int          hexv;
      int          escv;
      if (op) begin
         if (!str_failed) begin
            case (dec_mode)
               ced_pkg::MODE_ESC:
                  push_error(ced_pkg::ERR_TRAIL_BS, floor_sub(byte_idx, 16'd1));
               ced_pkg::MODE_HEX1:
                  push_error(ced_pkg::ERR_HEX_MISS, floor_sub(byte_idx, 16'd2));
               ced_pkg::MODE_HEX2: begin
                  if (pending_hex == 4'd0) begin
                     push_error(ced_pkg::ERR_HEX_ZERO, floor_sub(byte_idx, 16'd2));
                  end else begin
                     push_byte({4'd0, pending_hex});
                     push_done();
                  end
               end
               default:   push_done();
            endcase
         end
         clear_string();
         return;
      end
      pos = byte_idx;
      byte_idx = bump(byte_idx);
      if (str_failed) return;
      hexv = hex_digit_value(ch);
      if (dec_mode == ced_pkg::MODE_HEX2) begin
         if (hexv >= 0) begin
            v8 = {pending_hex, 4'(hexv)};
            dec_mode = ced_pkg::MODE_NORMAL;
            if (v8 == 8'd0) push_error(ced_pkg::ERR_HEX_ZERO, floor_sub(pos, 16'd1));
            else push_byte(v8);
            return;
         end
         if (pending_hex == 4'd0) begin
            push_error(ced_pkg::ERR_HEX_ZERO, floor_sub(pos, 16'd2));
            return;
         end
         // lone digit goes out first, the current byte is then decoded in normal mode
         push_byte({4'd0, pending_hex});
         dec_mode = ced_pkg::MODE_NORMAL;
      end
      case (dec_mode)
         ced_pkg::MODE_NORMAL: begin
            if (ch == ced_pkg::CH_BACKSLASH) dec_mode = ced_pkg::MODE_ESC;
            else push_byte(ch);
         end
         ced_pkg::MODE_ESC: begin
            if (ch == ced_pkg::CH_X) begin
               dec_mode = ced_pkg::MODE_HEX1;
            end else begin
               escv = escaped_byte(ch);
               if (escv < 0) begin
                  push_error(ced_pkg::ERR_UNK_ESC, floor_sub(pos, 16'd1));
               end else begin
                  dec_mode = ced_pkg::MODE_NORMAL;
                  push_byte(8'(escv));
               end
            end
         end
         default: begin
            if (hexv < 0) begin
               push_error(ced_pkg::ERR_HEX_MISS, floor_sub(pos, 16'd2));
            end else begin
               pending_hex = 4'(hexv);
               dec_mode = ced_pkg::MODE_HEX2;
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_string();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_kind == ced_pkg::KIND_ERROR) errors_seen++;
            if (expected_results.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with none pending, kind %0d data 0x%0h code %0d",
                        $time, rsp_kind, rsp_data, rsp_err_code);
            end else begin
               want = expected_results.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("data", want.data, rsp_data);
               check_field("err_code", want.err_code, rsp_err_code);
               check_field("err_pos", want.err_pos, rsp_err_pos);
               check_field("out_count", want.out_count, rsp_out_count);
               check_field("last", want.last, rsp_last);
            end
         end
         if (req_valid && !req_stall) decode_beat(req_op, req_ch);
      end
      outstanding <= expected_results.size();
   end

endmodule

// ----- tb/c_escape_string_decoder_tb.sv -----
// ---------------------------------------------------------------------------
// c_escape_string_decoder_tb
// Drives string literal bodies into the escape decoder: a directed set of
// escapes and errors, then random literals with broken escapes and noise.
// Sender bursts and receiver stalls vary.
// ---------------------------------------------------------------------------
module c_escape_string_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int RANDOM_BEATS  = 1700;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 20;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_op;
   logic [7:0]  req_ch;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data;
   logic [2:0]  rsp_err_code;
   logic [15:0] rsp_err_pos;
   logic [15:0] rsp_out_count;
   logic        rsp_last;

   int   fail_count;
   int   outstanding;
   int   results_seen;
   int   errors_seen;
   int   cycle_count;
   int   beats_sent;
   int   literal_count;
   int   burst_left;
   bit   sender_idles;
   logic hold_token;
   string escape_letters = "ntr0\\\"'bfva";

   c_escape_string_decoder dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_ch        (req_ch),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_data      (rsp_data),
      .rsp_err_code  (rsp_err_code),
      .rsp_err_pos   (rsp_err_pos),
      .rsp_out_count (rsp_out_count),
      .rsp_last      (rsp_last)
   );

   c_escape_string_decoder_checker decode_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_ch        (req_ch),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_data      (rsp_data),
      .rsp_err_code  (rsp_err_code),
      .rsp_err_pos   (rsp_err_pos),
      .rsp_out_count (rsp_out_count),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .results_seen  (results_seen),
      .errors_seen   (errors_seen)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still pending", cycle_count, outstanding);
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: its own stall pattern, plus a long hold each time hold_token flips
   initial begin
      stall_style_type stall_style;
      int   style_left;
      int   stall_phase;
      int   hold_left;
      logic hold_seen;
      stall_style = STALL_NONE;
      style_left = 0;
      stall_phase = 0;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_token !== hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
         end
         stall_phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (style_left == 0) begin
               stall_style = stall_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(50, 400);
            end
            style_left--;
            case (stall_style)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ((stall_phase % 7) < 3);
            endcase
         end
      end
   end

   task automatic send_beat(input logic op, input logic [7:0] ch);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_idles ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_ch <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= op;
      req_ch <= ch;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
      send_beat(1'b1, 8'($urandom_range(0, 255)));
      literal_count++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] hex_char(input int v);
      if (v < 10) return 8'("0" + v);
      if ($urandom_range(0, 1) != 0) return 8'("a" + v - 10);
      return 8'("A" + v - 10);
   endfunction

   function automatic int hex_pick();
      return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 15);
   endfunction

   task automatic send_random_literal(input int max_pieces, input bit noisy);
      int pieces;
      int pick;
      logic [7:0] c;
      pieces = $urandom_range(0, max_pieces);
      for (int i = 0; i < pieces; i++) begin
         pick = $urandom_range(0, 99);
         if (noisy) begin
            c = ($urandom_range(0, 3) == 0) ? ced_pkg::CH_BACKSLASH
                                            : 8'($urandom_range(0, 255));
            send_beat(1'b0, c);
         end else if (pick < 50) begin
            c = 8'($urandom_range(0, 255));
            if (c == ced_pkg::CH_BACKSLASH) send_beat(1'b0, c);
            send_beat(1'b0, c);
         end else if (pick < 68) begin
            send_beat(1'b0, ced_pkg::CH_BACKSLASH);
            send_beat(1'b0, escape_letters[$urandom_range(0, escape_letters.len() - 1)]);
         end else if (pick < 86) begin
            send_beat(1'b0, ced_pkg::CH_BACKSLASH);
            send_beat(1'b0, ced_pkg::CH_X);
            send_beat(1'b0, hex_char(hex_pick()));
            if ($urandom_range(0, 1) != 0) send_beat(1'b0, hex_char(hex_pick()));
         end else if (pick < 92) begin
            send_beat(1'b0, ced_pkg::CH_BACKSLASH);
            send_beat(1'b0, 8'($urandom_range(0, 255)));
         end else if (pick < 96) begin
            send_beat(1'b0, ced_pkg::CH_BACKSLASH);
            send_beat(1'b0, ced_pkg::CH_X);
            send_beat(1'b0, 8'($urandom_range(0, 255)));
         end else begin
            send_beat(1'b0, ced_pkg::CH_BACKSLASH);
         end
      end
      send_beat(1'b1, 8'($urandom_range(0, 255)));
      literal_count++;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= 1'b0;
      req_ch <= 8'h00;
      hold_token <= 1'b0;
      beats_sent = 0;
      literal_count = 0;
      burst_left = 0;
      sender_idles = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_beat(1'b0, 8'h00);
      send_beat(1'b0, 8'hFF);
      send_text("\\n\\x41\\x7Z");
      send_text("\\x5");
      send_text("\\qa");
      send_text("\\");

      while (beats_sent < RANDOM_BEATS) begin
         sender_idles = ($urandom_range(0, 3) != 0);
         if (literal_count == 30 || literal_count == 120) begin
            hold_token <= ~hold_token;
            sender_idles = 1'b0;
            for (int i = 0; i < 40; i++) send_beat(1'b0, 8'($urandom_range(0, 255)));
            send_beat(1'b1, 8'h00);
            literal_count++;
         end else if (literal_count % 45 == 0) begin
            wait_for_drain();
            send_random_literal(8, 1'b0);
         end else if ($urandom_range(0, 11) == 0) begin
            send_random_literal(12, 1'b1);
         end else begin
            send_random_literal(($urandom_range(0, 5) == 0) ? 30 : 8, 1'b0);
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d beats in %0d literals, with bursts, gaps and long receiver holds",
               beats_sent, literal_count);
      $display("%0d result beats compared, %0d of them error reports",
               results_seen, errors_seen);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
